/* rtl/sun_sensor_angle_estimator_core_defines.svh */
// ----------------------------------------------------------------------------
// Sun sensor angle estimator: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUN_SENSOR_ANGLE_ESTIMATOR_CORE_DEFINES_SVH
`define SUN_SENSOR_ANGLE_ESTIMATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SSAE_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSAE_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSAE_ASSERT_IMP(name, ck, rn, ante, cons)
`define SSAE_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif
`endif

/* rtl/ssae_pkg.sv */
// ----------------------------------------------------------------------------
// ssae_pkg
// Shared widths, constants, types and helpers of the sun sensor estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package ssae_pkg;
  localparam int RD_W       = 12;
  localparam int CAL_W      = 12;
  localparam int RATIO_W    = 16;
  localparam int REM_W      = CAL_W;
  localparam int LO_W       = RATIO_W;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = RATIO_W / DIV_STAGES;
  localparam int P_W        = 41;
  localparam int RECIP_W    = 21;
  localparam int T1_W       = 29;
  localparam int TAG_W      = 17;
  localparam int ANGLE_W    = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [RATIO_W-1:0] ONE_Q12   = 16'd4096;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 32'sh8000_0000;

  localparam logic [CAL_W-1:0] CAL_PLUS1_RST  = 12'd450;
  localparam logic [CAL_W-1:0] CAL_PLUS2_RST  = 12'd428;
  localparam logic [CAL_W-1:0] CAL_MINUS2_RST = 12'd550;
  localparam logic [CAL_W-1:0] CAL_MINUS1_RST = 12'd600;

  // Channel codes, which are also the configuration register indexes.
  localparam logic [1:0] CH_PLUS1  = 2'd0;
  localparam logic [1:0] CH_PLUS2  = 2'd1;
  localparam logic [1:0] CH_MINUS2 = 2'd2;
  localparam logic [1:0] CH_MINUS1 = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       neg;
    logic       wzero;
    logic [1:0] idx0;
  } side_t;

  function automatic logic signed [TAG_W-1:0] tag_q8(input logic [1:0] ch);
    logic signed [TAG_W-1:0] t;
    unique case (ch)
      CH_PLUS1:  t = 17'sd0;
      CH_PLUS2:  t = 17'sd23040;
      CH_MINUS2: t = -17'sd23040;
      default:   t = 17'sd46080;
    endcase
    return t;
  endfunction

  function automatic logic is_neg(input logic [1:0] c0, input logic [1:0] c1);
    return (c0 == CH_PLUS1 && c1 == CH_MINUS2) || (c0 == CH_PLUS2 && c1 == CH_PLUS1) ||
           (c0 == CH_MINUS2 && c1 == CH_MINUS1);
  endfunction
endpackage
`default_nettype wire

/* rtl/ssae_ratio_div.sv */
// ----------------------------------------------------------------------------
// ssae_ratio_div
// Pipelined restoring divider: reading * 4096 / cal, saturated to Q4.12.
// ----------------------------------------------------------------------------
`default_nettype none
module ssae_ratio_div (
  input  wire logic                        clk,
  input  wire logic [ssae_pkg::RD_W-1:0]   reading,
  input  wire logic [ssae_pkg::CAL_W-1:0]  cal,
  output logic      [ssae_pkg::RATIO_W-1:0] ratio
);
  localparam int NS = ssae_pkg::DIV_STAGES;

  logic [ssae_pkg::REM_W-1:0]   rem_r [1:NS];
  logic [ssae_pkg::LO_W-1:0]    lo_r  [1:NS];
  logic [ssae_pkg::RATIO_W-1:0] q_r   [1:NS];
  logic [ssae_pkg::CAL_W-1:0]   cal_r [1:NS];
  logic                         sat_r [1:NS];
  logic [ssae_pkg::REM_W-1:0]   rem_nxt [1:NS];
  logic [ssae_pkg::LO_W-1:0]    lo_nxt  [1:NS];
  logic [ssae_pkg::RATIO_W-1:0] q_nxt   [1:NS];
  logic [ssae_pkg::CAL_W-1:0]   cal_nxt [1:NS];
  logic                         sat_nxt [1:NS];

  always_comb begin
    logic [ssae_pkg::REM_W:0]     trial;
    logic [ssae_pkg::REM_W-1:0]   rem;
    logic [ssae_pkg::LO_W-1:0]    lo;
    logic [ssae_pkg::RATIO_W-1:0] q;
    logic [ssae_pkg::CAL_W-1:0]   c;
    logic                         sat;
    for (int k = 1; k <= NS; k++) begin
      if (k == 1) begin
        // The top reading bits form the first partial remainder; a quotient
        // of more than 16 bits only happens when reading >= 16 * cal.
        rem = {4'b0, reading[ssae_pkg::RD_W-1:4]};
        lo  = {reading[3:0], 12'b0};
        q   = '0;
        c   = cal;
        sat = {4'b0, reading} >= {cal, 4'b0};
      end else begin
        rem = rem_r[k-1];
        lo  = lo_r[k-1];
        q   = q_r[k-1];
        c   = cal_r[k-1];
        sat = sat_r[k-1];
      end
      for (int b = 0; b < ssae_pkg::DIV_BITS; b++) begin
        trial = {rem, lo[ssae_pkg::LO_W-1]};
        lo    = {lo[ssae_pkg::LO_W-2:0], 1'b0};
        if (trial >= {1'b0, c}) begin
          rem = ssae_pkg::REM_W'(trial - {1'b0, c});
          q   = {q[ssae_pkg::RATIO_W-2:0], 1'b1};
        end else begin
          rem = trial[ssae_pkg::REM_W-1:0];
          q   = {q[ssae_pkg::RATIO_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      lo_nxt[k]  = lo;
      q_nxt[k]   = q;
      cal_nxt[k] = c;
      sat_nxt[k] = sat;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      lo_r[k]  <= lo_nxt[k];
      q_r[k]   <= q_nxt[k];
      cal_r[k] <= cal_nxt[k];
      sat_r[k] <= sat_nxt[k];
    end
  end

  assign ratio = sat_r[NS] ? ssae_pkg::RATIO_MAX : q_r[NS];
endmodule
`default_nettype wire

/* rtl/ssae_recip_div.sv */
// ----------------------------------------------------------------------------
// ssae_recip_div
// Pipelined restoring divider for 2^33 / P, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ssae_recip_div (
  input  wire logic                        clk,
  input  wire logic [ssae_pkg::P_W-1:0]    p,
  output logic      [ssae_pkg::RECIP_W-1:0] q
);
  localparam int NS = ssae_pkg::RECIP_W;

  logic [ssae_pkg::P_W-1:0]     rem_r [1:NS];
  logic [ssae_pkg::P_W-1:0]     p_r   [1:NS];
  logic [ssae_pkg::RECIP_W-1:0] q_r   [1:NS];
  logic [ssae_pkg::P_W-1:0]     rem_nxt [1:NS];
  logic [ssae_pkg::RECIP_W-1:0] q_nxt   [1:NS];

  always_comb begin
    logic [ssae_pkg::P_W:0]       trial;
    logic [ssae_pkg::P_W-1:0]     rem;
    logic [ssae_pkg::P_W-1:0]     d;
    logic [ssae_pkg::RECIP_W-1:0] qq;
    for (int k = 1; k <= NS; k++) begin
      if (k == 1) begin
        // Dividend bits above the quotient range reduce to 2^12, below P.
        rem = ssae_pkg::P_W'(4096);
        d   = p;
        qq  = '0;
      end else begin
        rem = rem_r[k-1];
        d   = p_r[k-1];
        qq  = q_r[k-1];
      end
      trial = {rem, 1'b0};
      if (trial >= {1'b0, d}) begin
        rem_nxt[k] = ssae_pkg::P_W'(trial - {1'b0, d});
        q_nxt[k]   = {qq[ssae_pkg::RECIP_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[ssae_pkg::P_W-1:0];
        q_nxt[k]   = {qq[ssae_pkg::RECIP_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      q_r[k]   <= q_nxt[k];
      p_r[k]   <= (k == 1) ? p : p_r[k-1];
    end
  end

  assign q = q_r[NS];
endmodule
`default_nettype wire

/* rtl/sun_sensor_angle_estimator_core.sv */
// ----------------------------------------------------------------------------
// sun_sensor_angle_estimator_core
// Photodiode ratios, ordering and polynomial angle estimate, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    start, busy, in_*              start && !busy
//  result   out_valid, out_angle, out_*    out_valid, one cycle
//  config   cfg_valid, cfg_ready, cfg_*    cfg_valid && cfg_ready
//
// One sample set is taken every cycle while busy is low. Its result goes
// through the 4-stage ratio dividers, the sort and polynomial stages and
// the 21-stage reciprocal divider before it reaches the result ports.
// Reset is synchronous; busy is high only during reset and the first cycle
// after it. Results cannot be held off, so nothing stalls.
`default_nettype none
`include "sun_sensor_angle_estimator_core_defines.svh"
module sun_sensor_angle_estimator_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ssae_pkg::RD_W-1:0]         in_plus_axis1,
  input  wire logic [ssae_pkg::RD_W-1:0]         in_plus_axis2,
  input  wire logic [ssae_pkg::RD_W-1:0]         in_minus_axis2,
  input  wire logic [ssae_pkg::RD_W-1:0]         in_minus_axis1,
  input  wire logic                              in_last_in_batch,
  output logic                                   out_valid,
  output logic signed [ssae_pkg::ANGLE_W-1:0]    out_angle,
  output logic                                   out_batch_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ssae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssae_pkg::CAL_W-1:0]        cfg_data
);
  localparam int DL = ssae_pkg::DIV_STAGES;
  localparam int RL = ssae_pkg::RECIP_W;

  logic                        busy_r;
  logic [ssae_pkg::CAL_W-1:0]  cal_r [4];
  logic                        s0_valid_r, s0_last_r;
  logic [ssae_pkg::RD_W-1:0]   s0_rd_r [4];
  logic [ssae_pkg::RATIO_W-1:0] ratio [4];
  logic                        dv_valid_r [DL];
  logic                        dv_last_r  [DL];
  logic [ssae_pkg::RATIO_W-1:0] sa_ratio_r [4];
  logic [1:0]                  sa_idx_r [4];
  logic                        sa_valid_r, sa_last_r;
  logic [ssae_pkg::RATIO_W-1:0] sa_ratio_nxt [4];
  logic [1:0]                  sa_idx_nxt [4];
  logic [ssae_pkg::RATIO_W-1:0] sb_v_r, sb_w_r, sb_v_nxt, sb_w_nxt;
  ssae_pkg::side_t             sb_side_r, sb_side_nxt;
  logic [ssae_pkg::RATIO_W-1:0] m1_v_r, m1_w_r;
  logic [31:0]                 m1_vsq_r, m1_wsq_r;
  ssae_pkg::side_t             m1_side_r;
  logic [31:0]                 m2_vsq_r, m2_wsq_r;
  logic [ssae_pkg::RATIO_W-1:0] m2_v_r, m2_w_r;
  logic [35:0]                 m2_vcu_r, m2_wcu_r;
  logic [39:0]                 m2_vqu_r, m2_wqu_r;
  logic [47:0]                 vcu_full, wcu_full;
  logic [63:0]                 vqu_full, wqu_full;
  ssae_pkg::side_t             m2_side_r;
  logic [ssae_pkg::P_W-1:0]    m3_pv_r, m3_pw_r;
  ssae_pkg::side_t             m3_side_r;
  logic [44:0]                 pv_x10;
  ssae_pkg::side_t             rc_side_r [RL];
  logic [ssae_pkg::T1_W-1:0]   rc_t1_r   [RL];
  logic [ssae_pkg::RECIP_W-1:0] recip_q;
  ssae_pkg::side_t             fin;
  logic [ssae_pkg::T1_W:0]     mag;
  logic signed [33:0]          total;
  logic signed [ssae_pkg::ANGLE_W-1:0] angle_nxt;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r[ssae_pkg::CH_PLUS1]  <= ssae_pkg::CAL_PLUS1_RST;
      cal_r[ssae_pkg::CH_PLUS2]  <= ssae_pkg::CAL_PLUS2_RST;
      cal_r[ssae_pkg::CH_MINUS2] <= ssae_pkg::CAL_MINUS2_RST;
      cal_r[ssae_pkg::CH_MINUS1] <= ssae_pkg::CAL_MINUS1_RST;
    end else if (cfg_valid && cfg_ready) begin
      cal_r[cfg_index] <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s0_valid_r <= start && !busy_r;
    end
    s0_last_r  <= in_last_in_batch;
    s0_rd_r[0] <= in_plus_axis1;
    s0_rd_r[1] <= in_plus_axis2;
    s0_rd_r[2] <= in_minus_axis2;
    s0_rd_r[3] <= in_minus_axis1;
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    ssae_ratio_div u_div (
      .clk     (clk),
      .reading (s0_rd_r[g]),
      .cal     (cal_r[g]),
      .ratio   (ratio[g])
    );
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DL; k++) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else begin
        dv_valid_r[k] <= (k == 0) ? s0_valid_r : dv_valid_r[k-1];
      end
      dv_last_r[k] <= (k == 0) ? s0_last_r : dv_last_r[k-1];
    end
  end

  // First sort stage: pairs 01, 02, 03 bring the smallest ratio to the front.
  always_comb begin
    logic [ssae_pkg::RATIO_W-1:0] tr;
    logic [1:0]                   ti;
    tr = '0;
    ti = '0;
    for (int i = 0; i < 4; i++) begin
      sa_ratio_nxt[i] = ratio[i];
      sa_idx_nxt[i]   = 2'(i);
    end
    for (int j = 1; j < 4; j++) begin
      if (sa_ratio_nxt[0] > sa_ratio_nxt[j]) begin
        tr = sa_ratio_nxt[0]; ti = sa_idx_nxt[0];
        sa_ratio_nxt[0] = sa_ratio_nxt[j]; sa_idx_nxt[0] = sa_idx_nxt[j];
        sa_ratio_nxt[j] = tr; sa_idx_nxt[j] = ti;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= dv_valid_r[DL-1];
    end
    sa_last_r <= dv_last_r[DL-1];
    for (int i = 0; i < 4; i++) begin
      sa_ratio_r[i] <= sa_ratio_nxt[i];
      sa_idx_r[i]   <= sa_idx_nxt[i];
    end
  end

  // Second sort stage: pairs 12 and 13 settle position one; pair 23 does not
  // affect the estimate.
  always_comb begin
    logic [ssae_pkg::RATIO_W-1:0] r1;
    logic [1:0]                   i1;
    r1 = sa_ratio_r[1];
    i1 = sa_idx_r[1];
    if (r1 > sa_ratio_r[2]) begin
      r1 = sa_ratio_r[2]; i1 = sa_idx_r[2];
    end
    if (r1 > sa_ratio_r[3]) begin
      r1 = sa_ratio_r[3]; i1 = sa_idx_r[3];
    end
    sb_v_nxt = (sa_ratio_r[0] > ssae_pkg::ONE_Q12) ? sa_ratio_r[0] - ssae_pkg::ONE_Q12 : '0;
    sb_w_nxt = r1;
    sb_side_nxt.valid = sa_valid_r;
    sb_side_nxt.last  = sa_last_r;
    sb_side_nxt.neg   = ssae_pkg::is_neg(sa_idx_r[0], i1);
    sb_side_nxt.wzero = (r1 == '0);
    sb_side_nxt.idx0  = sa_idx_r[0];
  end

  assign vcu_full = m1_vsq_r * m1_v_r;
  assign wcu_full = m1_wsq_r * m1_w_r;
  assign vqu_full = m1_vsq_r * m1_vsq_r;
  assign wqu_full = m1_wsq_r * m1_wsq_r;
  assign pv_x10   = {m3_pv_r, 3'b0} + {2'b0, m3_pv_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_side_r <= '0;
      m1_side_r <= '0;
      m2_side_r <= '0;
      m3_side_r <= '0;
    end else begin
      sb_side_r <= sb_side_nxt;
      m1_side_r <= sb_side_r;
      m2_side_r <= m1_side_r;
      m3_side_r <= m2_side_r;
    end
    sb_v_r   <= sb_v_nxt;
    sb_w_r   <= sb_w_nxt;
    m1_v_r   <= sb_v_r;
    m1_w_r   <= sb_w_r;
    m1_vsq_r <= sb_v_r * sb_v_r;
    m1_wsq_r <= sb_w_r * sb_w_r;
    m2_v_r   <= m1_v_r;
    m2_w_r   <= m1_w_r;
    m2_vsq_r <= m1_vsq_r;
    m2_wsq_r <= m1_wsq_r;
    m2_vcu_r <= vcu_full[47:12];
    m2_wcu_r <= wcu_full[47:12];
    m2_vqu_r <= vqu_full[63:24];
    m2_wqu_r <= wqu_full[63:24];
    m3_pv_r  <= {1'b0, m2_vqu_r} + {5'b0, m2_vcu_r} + {9'b0, m2_vsq_r} + {13'b0, m2_v_r, 12'b0};
    m3_pw_r  <= {1'b0, m2_wqu_r} + {5'b0, m2_wcu_r} + {9'b0, m2_wsq_r} + {13'b0, m2_w_r, 12'b0};
  end

  ssae_recip_div u_recip (
    .clk (clk),
    .p   (m3_pw_r),
    .q   (recip_q)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < RL; k++) begin
      if (!rst_n) begin
        rc_side_r[k] <= '0;
      end else begin
        rc_side_r[k] <= (k == 0) ? m3_side_r : rc_side_r[k-1];
      end
      rc_t1_r[k] <= (k == 0) ? pv_x10[44:16] : rc_t1_r[k-1];
    end
  end

  // Final sum and saturation.
  assign fin = rc_side_r[RL-1];

  always_comb begin
    logic signed [33:0] mag_s;
    logic signed [33:0] tag_s;
    mag   = {1'b0, rc_t1_r[RL-1]} + {9'b0, recip_q};
    mag_s = $signed({4'b0, mag});
    tag_s = 34'(ssae_pkg::tag_q8(fin.idx0));
    total = fin.neg ? tag_s - mag_s : tag_s + mag_s;
    if (fin.wzero) begin
      angle_nxt = fin.neg ? ssae_pkg::ANGLE_MIN : ssae_pkg::ANGLE_MAX;
    end else if (total > 34'(ssae_pkg::ANGLE_MAX)) begin
      angle_nxt = ssae_pkg::ANGLE_MAX;
    end else if (total < 34'(ssae_pkg::ANGLE_MIN)) begin
      angle_nxt = ssae_pkg::ANGLE_MIN;
    end else begin
      angle_nxt = total[ssae_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fin.valid;
    end
    out_angle     <= angle_nxt;
    out_batch_end <= fin.last;
  end

  // A zero second ratio always ends at one of the two rails.
  `SSAE_ASSERT_NEXT(a_wzero_rail, clk, rst_n, fin.valid && fin.wzero, out_angle == ssae_pkg::ANGLE_MAX || out_angle == ssae_pkg::ANGLE_MIN)
  // With a positive sign both terms only add to the base angle.
  `SSAE_ASSERT_NEXT(a_pos_above_tag, clk, rst_n, fin.valid && !fin.neg && !fin.wzero, out_angle >= $past(ssae_pkg::tag_q8(fin.idx0)))
  `SSAE_ASSERT_IMP(a_no_out_busy, clk, rst_n, busy, !out_valid)
endmodule
`default_nettype wire
